[rtl/gmsv_pkg.sv]
package gmsv_pkg;

    localparam int MAX_ROWS = 65535;
    localparam int MAX_COLS = 65535;
    localparam int CNT_W    = $clog2(MAX_ROWS + 2);
    localparam int COL_W    = $clog2(MAX_COLS + 2);
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int FRL_W    = $clog2(MAX_COLS + 1);
    localparam int OUT_W    = 16;
    localparam int SYM_W    = 8;
    localparam int HDR_W    = 3;
    localparam int DEC_W    = CNT_W + 4;
    localparam int DEC_BASE = 10;
    localparam int TDATA_W  = 64;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [HDR_W-1:0] HDR_SYMS = HDR_W'(3);
    localparam logic [HDR_W-1:0] HDR_SAT  = HDR_W'(4);

    typedef enum logic [3:0] {
        PH_DIGITS  = 4'b0001,
        PH_SYMBOLS = 4'b0010,
        PH_ROWS    = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_NEWLINE   = 3'd1,
        ST_BAD_ROWS     = 3'd2,
        ST_BAD_HEADER   = 3'd3,
        ST_ROW_LEN      = 3'd4,
        ST_BAD_CHAR     = 3'd5,
        ST_ROW_MISMATCH = 3'd6,
        ST_NO_CELL      = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [OUT_W-1:0] rows_declared;
        logic [OUT_W-1:0] row_width;
        logic [SYM_W-1:0] empty_symbol;
        logic [SYM_W-1:0] obstacle_symbol;
        logic [SYM_W-1:0] full_symbol;
    } t_result;

endpackage

[rtl/grid_map_stream_validator.sv]
// Checks a text grid map that arrives one byte per request on the slave stream.
// Each accepted byte carries the map character in tdata and the end of the map in
// tlast. The block answers every map with one status request on the master stream,
// sent for the byte marked by tlast; other bytes produce nothing on that side.
// The status request holds the status code, the declared row count, the first row
// width and the three header symbols.
// An accepted byte is registered, then decoded by the parser as it leaves the input
// register, and the parser's result goes into the output register. A last byte thus
// passes the input register and its status request the output register before the
// status shows up on the master side. One byte can be accepted in every cycle while
// no last byte waits for a pending status request.
// When the receiver stalls, the status request waits in the output register while
// ordinary bytes keep flowing; only a further last byte waits until the pending
// status has been taken, and the slave side then holds tready low.
// Reset clears the parser to the start of a header and empties both registers.
// After each last byte the parser starts over, so the next byte opens a new map.
module grid_map_stream_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // byte_in
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // status, rows_declared, row_width,
                                       // empty_symbol, obstacle_symbol, full_symbol, zeros
);

    gmsv_pkg::t_item   in_item;
    gmsv_pkg::t_item   item;
    gmsv_pkg::t_result result;
    gmsv_pkg::t_result out_result;
    logic              item_valid;
    logic              fire;
    logic              out_full;
    logic              result_valid;

    assign in_item.byte_in   = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;

    assign fire = item_valid && !(item.last_byte && out_full);

    gmsv_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (fire),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    gmsv_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (item),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    gmsv_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (result_valid),
        .i_result (result),
        .o_full   (out_full),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {5'd0,
                           out_result.full_symbol,
                           out_result.obstacle_symbol,
                           out_result.empty_symbol,
                           out_result.row_width,
                           out_result.rows_declared,
                           out_result.status};

endmodule

[rtl/gmsv_in_stage.sv]
module gmsv_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gmsv_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output gmsv_pkg::t_item o_item
);

    logic            r_valid;
    gmsv_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/gmsv_parser.sv]
module gmsv_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  gmsv_pkg::t_item   i_item,
    output logic              o_result_valid,
    output gmsv_pkg::t_result o_result
);

    gmsv_pkg::t_phase                   r_phase, n_phase;
    logic [gmsv_pkg::CNT_W-1:0]         r_decl, n_decl;
    logic [gmsv_pkg::HDR_W-1:0]         r_symcnt, n_symcnt;
    logic [gmsv_pkg::SYM_W-1:0]         r_sym_e, n_sym_e;
    logic [gmsv_pkg::SYM_W-1:0]         r_sym_o, n_sym_o;
    logic [gmsv_pkg::SYM_W-1:0]         r_sym_f, n_sym_f;
    logic [gmsv_pkg::ROWS_W-1:0]        r_rows, n_rows;
    logic [gmsv_pkg::COL_W-1:0]         r_col, n_col;
    logic [gmsv_pkg::FRL_W-1:0]         r_frl, n_frl;
    logic                               r_bad, n_bad;
    logic                               r_seen, n_seen;
    gmsv_pkg::t_status                  r_err, n_err;

    logic [7:0]                  b;
    logic                        last;
    logic                        is_digit;
    logic                        is_nl;
    logic                        is_cell;
    logic [3:0]                  digit;
    logic [gmsv_pkg::DEC_W-1:0]  dec_v;
    logic [gmsv_pkg::COL_W-1:0]  col_inc;
    logic [gmsv_pkg::COL_W-1:0]  fin_col;
    logic                        fin_bad;
    logic [gmsv_pkg::CNT_W-1:0]  rows_next;
    gmsv_pkg::t_status           status;

    assign b        = i_item.byte_in;
    assign last     = i_item.last_byte;
    assign is_digit = (b >= gmsv_pkg::CH_ZERO) && (b <= gmsv_pkg::CH_NINE);
    assign is_nl    = (b == gmsv_pkg::CH_NL);
    assign is_cell  = (b == r_sym_e) || (b == r_sym_o);
    assign digit    = 4'(b - gmsv_pkg::CH_ZERO);
    assign dec_v    = gmsv_pkg::DEC_W'(r_decl) * gmsv_pkg::DEC_W'(gmsv_pkg::DEC_BASE)
                    + gmsv_pkg::DEC_W'(digit);
    assign col_inc  = (r_col <= gmsv_pkg::COL_W'(gmsv_pkg::MAX_COLS)) ? r_col + 1'b1 : r_col;
    assign fin_col  = is_nl ? r_col : col_inc;
    assign fin_bad  = is_nl ? r_bad : (r_bad || !is_cell);

    always_comb begin
        n_phase   = r_phase;
        n_decl    = r_decl;
        n_symcnt  = r_symcnt;
        n_sym_e   = r_sym_e;
        n_sym_o   = r_sym_o;
        n_sym_f   = r_sym_f;
        n_rows    = r_rows;
        n_col     = r_col;
        n_frl     = r_frl;
        n_bad     = r_bad;
        n_seen    = r_seen;
        n_err     = r_err;
        rows_next = '0;
        status    = gmsv_pkg::ST_OK;

        unique case (r_phase) inside
            gmsv_pkg::PH_DIGITS, gmsv_pkg::PH_SYMBOLS: begin
                if (r_phase == gmsv_pkg::PH_DIGITS && is_digit) begin
                    if (r_decl <= gmsv_pkg::CNT_W'(gmsv_pkg::MAX_ROWS)) begin
                        if (dec_v > gmsv_pkg::DEC_W'(gmsv_pkg::MAX_ROWS)) begin
                            n_decl = gmsv_pkg::CNT_W'(gmsv_pkg::MAX_ROWS + 1);
                        end else begin
                            n_decl = dec_v[gmsv_pkg::CNT_W-1:0];
                        end
                    end
                end else if (is_nl) begin
                    if (r_decl == '0 || r_decl > gmsv_pkg::CNT_W'(gmsv_pkg::MAX_ROWS)) begin
                        n_err   = gmsv_pkg::ST_BAD_ROWS;
                        n_phase = gmsv_pkg::PH_DONE;
                    end else if (r_symcnt != gmsv_pkg::HDR_SYMS) begin
                        n_err   = gmsv_pkg::ST_BAD_HEADER;
                        n_phase = gmsv_pkg::PH_DONE;
                    end else begin
                        n_phase = gmsv_pkg::PH_ROWS;
                    end
                end else begin
                    n_phase = gmsv_pkg::PH_SYMBOLS;
                    if (r_symcnt == gmsv_pkg::HDR_W'(0)) begin
                        n_sym_e = b;
                    end else if (r_symcnt == gmsv_pkg::HDR_W'(1)) begin
                        n_sym_o = b;
                    end else if (r_symcnt == gmsv_pkg::HDR_W'(2)) begin
                        n_sym_f = b;
                    end
                    if (r_symcnt < gmsv_pkg::HDR_SAT) begin
                        n_symcnt = r_symcnt + 1'b1;
                    end
                end
            end
            gmsv_pkg::PH_ROWS: begin
                if (!is_nl) begin
                    n_col = col_inc;
                    n_bad = fin_bad;
                    if (is_cell) begin
                        n_seen = 1'b1;
                    end
                end
                if (is_nl || last) begin
                    if (r_frl != '0 && fin_col != gmsv_pkg::COL_W'(r_frl)) begin
                        n_err   = gmsv_pkg::ST_ROW_LEN;
                        n_phase = gmsv_pkg::PH_DONE;
                    end else if (fin_col > gmsv_pkg::COL_W'(gmsv_pkg::MAX_COLS)) begin
                        n_err   = gmsv_pkg::ST_ROW_LEN;
                        n_phase = gmsv_pkg::PH_DONE;
                    end else if (fin_bad) begin
                        n_err   = gmsv_pkg::ST_BAD_CHAR;
                        n_phase = gmsv_pkg::PH_DONE;
                    end else begin
                        if (r_frl == '0) begin
                            n_frl = fin_col[gmsv_pkg::FRL_W-1:0];
                        end
                        rows_next = gmsv_pkg::CNT_W'(r_rows) + 1'b1;
                        n_rows    = rows_next[gmsv_pkg::ROWS_W-1:0];
                        if (rows_next >= r_decl) begin
                            n_phase = gmsv_pkg::PH_DONE;
                        end
                    end
                    n_col = '0;
                    n_bad = 1'b0;
                end
            end
            gmsv_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase

        // A final newline with rows open counts an empty row, or ST_ROW_LEN if width is set.
        if (last && is_nl && n_phase == gmsv_pkg::PH_ROWS) begin
            if (n_frl != '0) begin
                n_err   = gmsv_pkg::ST_ROW_LEN;
                n_phase = gmsv_pkg::PH_DONE;
            end else begin
                rows_next = gmsv_pkg::CNT_W'(n_rows) + 1'b1;
                n_rows    = rows_next[gmsv_pkg::ROWS_W-1:0];
                if (rows_next >= n_decl) begin
                    n_phase = gmsv_pkg::PH_DONE;
                end
            end
        end

        if (n_err != gmsv_pkg::ST_OK) begin
            status = n_err;
        end else if (n_phase == gmsv_pkg::PH_DIGITS || n_phase == gmsv_pkg::PH_SYMBOLS) begin
            status = gmsv_pkg::ST_NO_NEWLINE;
        end else if (gmsv_pkg::CNT_W'(n_rows) != n_decl) begin
            status = gmsv_pkg::ST_ROW_MISMATCH;
        end else if (!n_seen) begin
            status = gmsv_pkg::ST_NO_CELL;
        end
    end

    assign o_result_valid           = i_fire && last;
    assign o_result.status          = status;
    assign o_result.rows_declared   = (n_decl > gmsv_pkg::CNT_W'({gmsv_pkg::OUT_W{1'b1}}))
                                    ? {gmsv_pkg::OUT_W{1'b1}}
                                    : n_decl[gmsv_pkg::OUT_W-1:0];
    assign o_result.row_width       = gmsv_pkg::OUT_W'(n_frl);
    assign o_result.empty_symbol    = n_sym_e;
    assign o_result.obstacle_symbol = n_sym_o;
    assign o_result.full_symbol     = n_sym_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && last)) begin
            r_phase  <= gmsv_pkg::PH_DIGITS;
            r_decl   <= '0;
            r_symcnt <= '0;
            r_sym_e  <= '0;
            r_sym_o  <= '0;
            r_sym_f  <= '0;
            r_rows   <= '0;
            r_col    <= '0;
            r_frl    <= '0;
            r_bad    <= 1'b0;
            r_seen   <= 1'b0;
            r_err    <= gmsv_pkg::ST_OK;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_decl   <= n_decl;
            r_symcnt <= n_symcnt;
            r_sym_e  <= n_sym_e;
            r_sym_o  <= n_sym_o;
            r_sym_f  <= n_sym_f;
            r_rows   <= n_rows;
            r_col    <= n_col;
            r_frl    <= n_frl;
            r_bad    <= n_bad;
            r_seen   <= n_seen;
            r_err    <= n_err;
        end
    end

endmodule

[rtl/gmsv_out_stage.sv]
module gmsv_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  gmsv_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output gmsv_pkg::t_result o_result
);

    logic              r_valid;
    gmsv_pkg::t_result r_result;

    assign o_valid  = r_valid;
    assign o_full   = r_valid && !i_ready;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[bench/tb_grid_map_stream_validator.sv]
module tb_grid_map_stream_validator;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // byte_in
    logic        s_axis_tlast = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // status, rows_declared, row_width,
                                        // empty_symbol, obstacle_symbol, full_symbol, zeros

    grid_map_stream_validator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    // Shadow copy of the parser state.
    gmsv_pkg::t_phase  parse_phase;
    logic [16:0]       rows_decl;
    logic [16:0]       rows_done;
    logic [16:0]       col_cnt;
    logic [15:0]       first_width;
    logic [2:0]        sym_cnt;
    logic [7:0]        sym_empty;
    logic [7:0]        sym_obst;
    logic [7:0]        sym_full;
    bit                row_bad_char;
    bit                any_cell;
    gmsv_pkg::t_status first_error;

    gmsv_pkg::t_result expected_status[$];
    logic [7:0]        map_bytes[$];
    int                src_idle;
    int                sink_stall;
    int                bytes_sent;
    int                mismatch_count;
    gmsv_pkg::t_result want;

    function automatic void clear_parser();
        parse_phase  = gmsv_pkg::PH_DIGITS;
        rows_decl    = '0;
        rows_done    = '0;
        col_cnt      = '0;
        first_width  = '0;
        sym_cnt      = '0;
        sym_empty    = '0;
        sym_obst     = '0;
        sym_full     = '0;
        row_bad_char = 1'b0;
        any_cell     = 1'b0;
        first_error  = gmsv_pkg::ST_OK;
    endfunction

    function automatic void raise_error(input gmsv_pkg::t_status code);
        first_error = code;
        parse_phase = gmsv_pkg::PH_DONE;
    endfunction

    function automatic void close_row();
        if (first_width != 0 && col_cnt != {1'b0, first_width}) begin
            raise_error(gmsv_pkg::ST_ROW_LEN);
        end else if (col_cnt > gmsv_pkg::MAX_COLS) begin
            raise_error(gmsv_pkg::ST_ROW_LEN);
        end else if (row_bad_char) begin
            raise_error(gmsv_pkg::ST_BAD_CHAR);
        end else begin
            if (first_width == 0) begin
                first_width = col_cnt[15:0];
            end
            rows_done = rows_done + 1'b1;
            if (rows_done >= rows_decl) begin
                parse_phase = gmsv_pkg::PH_DONE;
            end
        end
        col_cnt      = '0;
        row_bad_char = 1'b0;
    endfunction

    function automatic void parse_map_byte(input logic [7:0] b, input bit last);
        int                acc;
        gmsv_pkg::t_result res;
        if (parse_phase == gmsv_pkg::PH_DIGITS && b >= gmsv_pkg::CH_ZERO
                && b <= gmsv_pkg::CH_NINE) begin
            if (rows_decl <= gmsv_pkg::MAX_ROWS) begin
                acc = int'(rows_decl) * gmsv_pkg::DEC_BASE + int'(b) - int'(gmsv_pkg::CH_ZERO);
                rows_decl = (acc > gmsv_pkg::MAX_ROWS) ? 17'(gmsv_pkg::MAX_ROWS + 1) : 17'(acc);
            end
        end else if (parse_phase == gmsv_pkg::PH_DIGITS
                || parse_phase == gmsv_pkg::PH_SYMBOLS) begin
            if (b == gmsv_pkg::CH_NL) begin
                if (rows_decl == 0 || rows_decl > gmsv_pkg::MAX_ROWS) begin
                    raise_error(gmsv_pkg::ST_BAD_ROWS);
                end else if (sym_cnt != gmsv_pkg::HDR_SYMS) begin
                    raise_error(gmsv_pkg::ST_BAD_HEADER);
                end else begin
                    parse_phase = gmsv_pkg::PH_ROWS;
                end
            end else begin
                parse_phase = gmsv_pkg::PH_SYMBOLS;
                case (sym_cnt)
                    3'd0: sym_empty = b;
                    3'd1: sym_obst  = b;
                    3'd2: sym_full  = b;
                    default: ;
                endcase
                if (sym_cnt < gmsv_pkg::HDR_SAT) begin
                    sym_cnt = sym_cnt + 1'b1;
                end
            end
        end else if (parse_phase == gmsv_pkg::PH_ROWS) begin
            if (b == gmsv_pkg::CH_NL) begin
                close_row();
            end else begin
                if (col_cnt <= gmsv_pkg::MAX_COLS) begin
                    col_cnt = col_cnt + 1'b1;
                end
                if (b != sym_empty && b != sym_obst) begin
                    row_bad_char = 1'b1;
                end else begin
                    any_cell = 1'b1;
                end
                if (last) begin
                    close_row();
                end
            end
        end
        if (last) begin
            // Newline at the end, rows missing: an empty row, or ST_ROW_LEN if width set.
            if (parse_phase == gmsv_pkg::PH_ROWS && b == gmsv_pkg::CH_NL) begin
                close_row();
            end
            if (first_error != gmsv_pkg::ST_OK) begin
                res.status = first_error;
            end else if (parse_phase == gmsv_pkg::PH_DIGITS
                    || parse_phase == gmsv_pkg::PH_SYMBOLS) begin
                res.status = gmsv_pkg::ST_NO_NEWLINE;
            end else if (rows_done != rows_decl) begin
                res.status = gmsv_pkg::ST_ROW_MISMATCH;
            end else if (!any_cell) begin
                res.status = gmsv_pkg::ST_NO_CELL;
            end else begin
                res.status = gmsv_pkg::ST_OK;
            end
            res.rows_declared   = (rows_decl > 17'hFFFF) ? 16'hFFFF : rows_decl[15:0];
            res.row_width       = first_width;
            res.empty_symbol    = sym_empty;
            res.obstacle_symbol = sym_obst;
            res.full_symbol     = sym_full;
            expected_status.push_back(res);
            clear_parser();
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_status.size() == 0) begin
                $error("status request with none expected: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_status.pop_front();
                check_field("status", want.status, m_axis_tdata[2:0]);
                check_field("rows_declared", want.rows_declared, m_axis_tdata[18:3]);
                check_field("row_width", want.row_width, m_axis_tdata[34:19]);
                check_field("empty_symbol", want.empty_symbol, m_axis_tdata[42:35]);
                check_field("obstacle_symbol", want.obstacle_symbol, m_axis_tdata[50:43]);
                check_field("full_symbol", want.full_symbol, m_axis_tdata[58:51]);
                check_field("padding", 0, m_axis_tdata[63:59]);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        parse_map_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_map();
        foreach (map_bytes[i]) begin
            send_byte(map_bytes[i], i == map_bytes.size() - 1);
        end
        map_bytes.delete();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_status.size() != 0);
    endtask

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            map_bytes.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] rand_symbol(input bit no_digit);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == gmsv_pkg::CH_NL
                   || (no_digit && b >= gmsv_pkg::CH_ZERO && b <= gmsv_pkg::CH_NINE));
        return b;
    endfunction

    task automatic test_header_and_rows();
        string maps[$];
        maps = '{
            "3.o*\n..o\no..\n.o.\n",
            "2.o*\n..\n..",
            "2.o*\n..\n",
            "2.o*\n\n",
            "12",
            "\n",
            ".o*\n.\n",
            "0.o*\n.\n",
            "99999.o*\n.",
            "65535.o*\n..\n",
            "65536.o*\n.\n",
            "1.o\n.",
            "1.o*x\n.",
            "1ab5c6\n.",
            "2.o*\n..\n...\n",
            "2.o*\n.x\n..\n",
            "1.o*\n.xx",
            "2.o*\n..\n.x.",
            "1.o*\n..\ngarbage",
            "2.o*\n\n.o\n.o\n",
            "1.o*",
            "1.o*\n.*\n",
            "3.o*\n..\n.."
        };
        foreach (maps[i]) begin
            put_str(maps[i]);
            send_map();
        end
        // Zero byte and high-bit bytes as header symbols and cells.
        map_bytes = '{8'h31, 8'h00, 8'hFF, 8'h80, gmsv_pkg::CH_NL, 8'hFF, 8'h00,
                      gmsv_pkg::CH_NL};
        send_map();
        map_bytes = '{8'h31, 8'h7F, 8'h80, 8'h55, gmsv_pkg::CH_NL, 8'h80, 8'h7F, 8'hAA};
        send_map();
    endtask

    task automatic test_random_maps(input int target);
        int         stop_at;
        int         nrows;
        int         decl;
        int         width;
        int         rw;
        logic [7:0] e_sym;
        logic [7:0] o_sym;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                nrows = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
                width = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
                e_sym = rand_symbol(1'b1);
                o_sym = rand_symbol(1'b0);
                decl  = nrows;
                if ($urandom_range(19) == 0) begin
                    decl = (nrows > 1 && $urandom_range(1)) ? nrows - 1 : nrows + 1;
                end
                if ($urandom_range(9) == 0) begin
                    put_str("0");
                end
                put_str($sformatf("%0d", decl));
                map_bytes.push_back(e_sym);
                if ($urandom_range(29) != 0) begin
                    map_bytes.push_back(o_sym);
                end
                map_bytes.push_back(rand_symbol(1'b0));
                if ($urandom_range(29) == 0) begin
                    map_bytes.push_back(rand_symbol(1'b0));
                end
                map_bytes.push_back(gmsv_pkg::CH_NL);
                for (int r = 0; r < nrows; r++) begin
                    rw = width;
                    if ($urandom_range(24) == 0) begin
                        rw = (rw > 0 && $urandom_range(1)) ? rw - 1 : rw + 1;
                    end
                    repeat (rw) begin
                        if ($urandom_range(49) == 0) begin
                            map_bytes.push_back(rand_symbol(1'b0));
                        end else begin
                            map_bytes.push_back($urandom_range(1) ? e_sym : o_sym);
                        end
                    end
                    if (r < nrows - 1 || $urandom_range(1) || rw == 0) begin
                        map_bytes.push_back(gmsv_pkg::CH_NL);
                    end
                end
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 4)) map_bytes.push_back(8'($urandom_range(255)));
                end
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    case ($urandom_range(4))
                        0: map_bytes.push_back(
                               8'($urandom_range(gmsv_pkg::CH_ZERO, gmsv_pkg::CH_NINE)));
                        1: map_bytes.push_back(gmsv_pkg::CH_NL);
                        default: map_bytes.push_back(8'($urandom_range(255)));
                    endcase
                end
            end
            send_map();
            if ($urandom_range(9) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        clear_parser();
        bytes_sent     = 0;
        mismatch_count = 0;
        src_idle       = 24;
        sink_stall     = 50;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_and_rows();
        test_random_maps(360);
        wait_drained();

        src_idle   = 50;
        sink_stall = 24;
        test_random_maps(360);
        wait_drained();

        src_idle   = 0;
        sink_stall = 0;
        test_random_maps(360);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
